// ===== sv/rpn_calc_pkg.sv =====
package rpn_calc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_W       = DATA_W + FRAC_BITS;
    localparam int ITER_W      = $clog2(DIV_W + 1);

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;
    localparam logic [2:0] OP_QUERY = 3'd6;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] operand_value;
    } in_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } out_item_t;

endpackage

// ===== sv/rpn_calc_alu.sv =====
module rpn_calc_alu (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rpn_calc_pkg::alu_req_t                req,
    input  logic signed [rpn_calc_pkg::DATA_W-1:0] a_in,
    input  logic signed [rpn_calc_pkg::DATA_W-1:0] b_in,
    output rpn_calc_pkg::alu_rsp_t                rsp,
    output logic signed [rpn_calc_pkg::DATA_W-1:0] result
);

    localparam int DW = rpn_calc_pkg::DATA_W;
    localparam int PW = rpn_calc_pkg::PROD_W;
    localparam int QW = rpn_calc_pkg::DIV_W;
    localparam int IW = rpn_calc_pkg::ITER_W;
    localparam logic [PW-1:0] DIV_MASK = {{(PW - QW){1'b0}}, {QW{1'b1}}};
    localparam logic [DW-1:0] SAT_MAX  = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0] SAT_MIN  = {1'b1, {(DW - 1){1'b0}}};

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_RUN  = 3'b010,
        A_FIN  = 3'b100
    } alu_state_t;

    alu_state_t             state_reg, state_next;
    rpn_calc_pkg::alu_op_t  op_reg;
    logic                   neg_reg;
    logic                   dz_reg;
    logic                   carry_reg;
    logic                   done_reg;
    logic [IW-1:0]          cnt_reg;
    logic [DW-1:0]          opa_reg;
    logic [DW-1:0]          opb_reg;
    logic [DW:0]            acc_reg;
    logic [PW-1:0]          wk_reg;
    logic [DW-1:0]          res_reg;

    logic [DW-1:0] a_u, b_u, abs_a, abs_b;
    logic          add_bit, add_carry, add_hi, add_ovf;
    logic [DW-1:0] add_res;
    logic [DW:0]   mul_sum;
    logic [DW:0]   div_try;
    logic          div_ge;
    logic [DW:0]   div_rem;
    logic [PW-1:0] mag;
    logic          mag_ovf;
    logic [DW-1:0] mag_res;
    logic [IW-1:0] last_cnt;

    assign a_u   = a_in;
    assign b_u   = b_in;
    assign abs_a = a_u[DW-1] ? (~a_u + DW'(1)) : a_u;
    assign abs_b = b_u[DW-1] ? (~b_u + DW'(1)) : b_u;

    // One sum bit per cycle; the operands shift arithmetically so that their
    // sign bits remain at bit zero once all bits have gone by.
    assign add_bit   = opa_reg[0] ^ opb_reg[0] ^ carry_reg;
    assign add_carry = (opa_reg[0] & opb_reg[0]) | (carry_reg & (opa_reg[0] ^ opb_reg[0]));
    assign add_hi    = add_bit;
    assign add_ovf   = add_hi != wk_reg[PW-1];
    assign add_res   = add_ovf ? (add_hi ? SAT_MIN : SAT_MAX) : wk_reg[PW-1:PW-DW];

    assign mul_sum = {1'b0, acc_reg[DW-1:0]} + (wk_reg[0] ? {1'b0, opa_reg} : {(DW + 1){1'b0}});

    assign div_try = {acc_reg[DW-1:0], wk_reg[QW-1]};
    assign div_ge  = div_try >= {1'b0, opb_reg};
    assign div_rem = div_ge ? (div_try - {1'b0, opb_reg}) : div_try;

    always_comb begin
        if (op_reg == rpn_calc_pkg::ALU_MUL) begin
            mag = {acc_reg[DW-1:0], wk_reg[DW-1:0]} >> rpn_calc_pkg::FRAC_BITS;
        end else begin
            mag = wk_reg & DIV_MASK;
        end
    end

    assign mag_ovf = (|mag[PW-1:DW]) | (mag[DW-1] & (~neg_reg | (|mag[DW-2:0])));
    assign mag_res = mag_ovf ? (neg_reg ? SAT_MIN : SAT_MAX)
                             : (neg_reg ? (~mag[DW-1:0] + DW'(1)) : mag[DW-1:0]);

    assign last_cnt = (op_reg == rpn_calc_pkg::ALU_DIV) ? IW'(QW - 1) : IW'(DW - 1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    if (req.op == rpn_calc_pkg::ALU_DIV && b_u == '0) begin
                        state_next = A_FIN;
                    end else begin
                        state_next = A_RUN;
                    end
                end
            end
            A_RUN: begin
                if (cnt_reg == last_cnt) begin
                    state_next = A_FIN;
                end
            end
            A_FIN: state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == A_FIN);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == A_IDLE && req.start) begin
            op_reg    <= req.op;
            neg_reg   <= a_u[DW-1] ^ b_u[DW-1];
            cnt_reg   <= '0;
            carry_reg <= (req.op == rpn_calc_pkg::ALU_SUB);
            dz_reg    <= (req.op == rpn_calc_pkg::ALU_DIV) && (b_u == '0);
            acc_reg   <= '0;
            case (req.op)
                rpn_calc_pkg::ALU_ADD: begin
                    opa_reg <= a_u;
                    opb_reg <= b_u;
                end
                rpn_calc_pkg::ALU_SUB: begin
                    opa_reg <= a_u;
                    opb_reg <= ~b_u;
                end
                rpn_calc_pkg::ALU_MUL: begin
                    opa_reg <= abs_a;
                    opb_reg <= abs_b;
                    wk_reg  <= {{(PW - DW){1'b0}}, abs_b};
                end
                default: begin
                    opa_reg <= abs_a;
                    opb_reg <= abs_b;
                    wk_reg  <= PW'({{(PW - DW){1'b0}}, abs_a} << rpn_calc_pkg::FRAC_BITS);
                end
            endcase
        end else if (state_reg == A_RUN) begin
            cnt_reg <= cnt_reg + IW'(1);
            case (op_reg)
                rpn_calc_pkg::ALU_MUL: begin
                    acc_reg            <= {1'b0, mul_sum[DW:1]};
                    wk_reg[DW-1:0]     <= {mul_sum[0], wk_reg[DW-1:1]};
                end
                rpn_calc_pkg::ALU_DIV: begin
                    acc_reg <= div_rem;
                    wk_reg  <= {wk_reg[PW-2:0], div_ge};
                end
                default: begin
                    opa_reg   <= {opa_reg[DW-1], opa_reg[DW-1:1]};
                    opb_reg   <= {opb_reg[DW-1], opb_reg[DW-1:1]};
                    carry_reg <= add_carry;
                    wk_reg    <= {add_bit, wk_reg[PW-1:1]};
                end
            endcase
        end else if (state_reg == A_FIN) begin
            if (op_reg == rpn_calc_pkg::ALU_ADD || op_reg == rpn_calc_pkg::ALU_SUB) begin
                res_reg <= add_res;
            end else begin
                res_reg <= mag_res;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = res_reg;

endmodule

// ===== sv/rpn_stack_calculator_unit.sv =====
// Reverse-Polish stack engine over signed Q16.16 values with a 16-entry stack.
// Each input beat carries an operation (push, add, subtract, multiply, divide,
// clear, query) and produces exactly one output beat with a status, the new top
// of stack (zero when empty) and the new depth. Push, clear, query and a binary
// operation that underflows pass through the top-of-stack read and the output
// load before the result is presented. Add and subtract run bit-serially and
// multiply shift-adds one multiplier bit per cycle; divide is a restoring divider
// producing one quotient bit per cycle over 48 steps, while a divide by zero
// skips the steps. There is one shared arithmetic unit, and the stack memory has
// a single read port that fetches the two operands one after the other; one
// operation is processed at a time, and a new one may be accepted while the
// previous result waits in the output register. A finished result that finds
// the output register still full waits for it, and input stalls meanwhile.
module rpn_stack_calculator_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  rpn_calc_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rpn_calc_pkg::out_item_t m_data
);

    localparam int DW = rpn_calc_pkg::DATA_W;
    localparam int CW = rpn_calc_pkg::DEPTH_W;
    localparam int AW = rpn_calc_pkg::ADDR_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RDB  = 6'b000010,
        S_RDA  = 6'b000100,
        S_ALU  = 6'b001000,
        S_TOP  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    rpn_calc_pkg::status_t   status_reg, status_next;
    logic [2:0]              op_reg;
    logic [DW-1:0]           b_reg;
    logic [DW-1:0]           rd_data_reg;
    logic                    m_valid_reg;
    rpn_calc_pkg::out_item_t m_data_reg;
    logic [DW-1:0]           mem [rpn_calc_pkg::STACK_DEPTH];

    logic                    wr_en, rd_en, load_out;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [DW-1:0]           wr_data;
    logic [CW-1:0]           count_m1, count_m2;
    rpn_calc_pkg::alu_req_t  alu_req;
    rpn_calc_pkg::alu_rsp_t  alu_rsp;
    logic signed [DW-1:0]    alu_result;

    assign s_ready  = (state_reg == S_IDLE);
    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = s_data.operand_value;
        rd_en       = 1'b0;
        rd_addr     = count_m1[AW-1:0];
        load_out    = 1'b0;
        alu_req     = '0;
        unique case (op_reg)
            rpn_calc_pkg::OP_SUB: alu_req.op = rpn_calc_pkg::ALU_SUB;
            rpn_calc_pkg::OP_MUL: alu_req.op = rpn_calc_pkg::ALU_MUL;
            rpn_calc_pkg::OP_DIV: alu_req.op = rpn_calc_pkg::ALU_DIV;
            default:              alu_req.op = rpn_calc_pkg::ALU_ADD;
        endcase

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    status_next = rpn_calc_pkg::ST_OK;
                    state_next  = S_TOP;
                    unique case (s_data.operation) inside
                        rpn_calc_pkg::OP_PUSH: begin
                            if (count_reg == CW'(rpn_calc_pkg::STACK_DEPTH)) begin
                                status_next = rpn_calc_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        rpn_calc_pkg::OP_ADD, rpn_calc_pkg::OP_SUB,
                        rpn_calc_pkg::OP_MUL, rpn_calc_pkg::OP_DIV: begin
                            if (count_reg < CW'(2)) begin
                                status_next = rpn_calc_pkg::ST_UNDERFLOW;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = S_RDB;
                            end
                        end
                        rpn_calc_pkg::OP_CLEAR: count_next = '0;
                        default: ;
                    endcase
                end
            end
            S_RDB: begin
                rd_en      = 1'b1;
                rd_addr    = count_m2[AW-1:0];
                state_next = S_RDA;
            end
            S_RDA: begin
                // Both operands leave the stack here; the result, if any, is pushed back.
                alu_req.start = 1'b1;
                count_next    = count_m2;
                state_next    = S_ALU;
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.div_zero) begin
                        status_next = rpn_calc_pkg::ST_DIVZERO;
                    end else begin
                        wr_en      = 1'b1;
                        wr_data    = alu_result;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = S_TOP;
                end
            end
            S_TOP: begin
                rd_en      = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            status_reg  <= rpn_calc_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (s_valid && s_ready) begin
            op_reg <= s_data.operation;
        end
        if (state_reg == S_RDB) begin
            b_reg <= rd_data_reg;
        end
        if (load_out) begin
            m_data_reg.status    <= status_reg;
            m_data_reg.top_value <= (count_reg == '0) ? '0 : rd_data_reg;
            m_data_reg.depth     <= count_reg;
        end
    end

    rpn_calc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a_in    (rd_data_reg),
        .b_in    (b_reg),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(rpn_calc_pkg::STACK_DEPTH))
        else $error("stack count exceeds the stack depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.depth == '0) |-> (m_data.top_value == '0))
        else $error("empty stack reported with a nonzero top value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == rpn_calc_pkg::ST_UNDERFLOW) |-> (m_data.depth < CW'(2)))
        else $error("underflow reported with two or more entries");

    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> (state_reg == S_ALU))
        else $error("arithmetic unit finished outside the wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.operation == rpn_calc_pkg::OP_PUSH
            && count_reg == CW'(rpn_calc_pkg::STACK_DEPTH))
        |=> (count_reg == CW'(rpn_calc_pkg::STACK_DEPTH)
            && status_reg == rpn_calc_pkg::ST_FULL))
        else $error("push to a full stack was not rejected");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rpn_calc_pkg::*;

    localparam int ITEM_TOTAL = 1050;
    localparam int CYCLE_LIMIT = 800_000;
    localparam int IDLE_PCT = 22;
    localparam int HOLD_AT = 250;
    localparam int HOLD_LEN = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [2:0] ARITH_OPS [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    in_item_t pending_items[$];
    out_item_t expected_results[$];

    // Shadow of the calculator stack.
    logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int stack_fill = 0;

    int cycle_count = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int error_count = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int hold_left = 0;
    bit hold_done = 1'b0;

    rpn_stack_calculator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Applies one operation to the shadow stack and returns the result beat it should produce.
    function automatic out_item_t calc_step(in_item_t item);
        longint a;
        longint b;
        longint r;
        status_t st;
        bit keep;
        out_item_t res;
        st = ST_OK;
        keep = 1'b1;
        r = 0;
        case (item.operation)
            OP_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    stack_mem[stack_fill] = item.operand_value;
                    stack_fill++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (stack_fill < 2) begin
                    st = ST_UNDERFLOW;
                end else begin
                    b = stack_mem[stack_fill - 1];
                    a = stack_mem[stack_fill - 2];
                    stack_fill -= 2;
                    case (item.operation)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = (a * b) / (longint'(1) << FRAC_BITS);
                        default: begin
                            if (b == 0) begin
                                keep = 1'b0;
                                st = ST_DIVZERO;
                            end else begin
                                r = (a * (longint'(1) << FRAC_BITS)) / b;
                            end
                        end
                    endcase
                    if (keep) begin
                        if (r > longint'(Q_MAX)) begin
                            r = Q_MAX;
                        end else if (r < longint'(Q_MIN)) begin
                            r = Q_MIN;
                        end
                        stack_mem[stack_fill] = r[DATA_W-1:0];
                        stack_fill++;
                    end
                end
            end
            OP_CLEAR: begin
                stack_fill = 0;
            end
            default: begin
            end
        endcase
        res.status = st;
        res.top_value = (stack_fill > 0) ? stack_mem[stack_fill - 1] : '0;
        res.depth = DEPTH_W'(stack_fill);
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            return '0;
        end else if (sel < 20) begin
            case ($urandom_range(0, 4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return Q_ONE;
                3: return -Q_ONE;
                default: return 32'sh0000_0001;
            endcase
        end else if (sel < 60) begin
            // Modest magnitudes keep products out of saturation.
            return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        end else begin
            return $signed($urandom());
        end
    endfunction

    task automatic add_item(logic [2:0] op, logic signed [DATA_W-1:0] value);
        in_item_t item;
        item.operation = op;
        item.operand_value = value;
        pending_items.push_back(item);
    endtask

    // Sender: offers the next pending beat, holding valid and payload until accepted.
    always @(posedge aclk) begin
        bit calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            calm = items_accepted >= 450 && items_accepted < 600;
            if (s_valid && s_ready) begin
                expected_results.push_back(calc_step(s_data));
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        bit calm;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            status_seen[m_data.status]++;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: status %0d top_value %h depth %0d",
                       m_data.status, m_data.top_value, m_data.depth);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.top_value !== want.top_value) begin
                    $error("top_value: expected %h, actual %h", want.top_value, m_data.top_value);
                    error_count++;
                end
                if (m_data.depth !== want.depth) begin
                    $error("depth: expected %0d, actual %0d", want.depth, m_data.depth);
                    error_count++;
                end
            end
        end
        calm = items_accepted >= 450 && items_accepted < 600;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            // Long back-pressure so the block fills and stalls its input.
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles.", cycle_count);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int kind;
        int n;
        // Directed: empty cases, saturation at both ends, divide by zero, odd opcodes.
        add_item(OP_QUERY, Q_MAX);
        add_item(OP_ADD, '0);
        add_item(OP_PUSH, Q_MAX);
        add_item(OP_SUB, Q_MIN);
        add_item(OP_PUSH, Q_MAX);
        add_item(OP_ADD, '0);
        add_item(OP_PUSH, Q_MIN);
        add_item(OP_SUB, '0);
        add_item(OP_PUSH, Q_MIN);
        add_item(OP_MUL, '0);
        add_item(OP_PUSH, '0);
        add_item(OP_DIV, '0);
        add_item(OP_PUSH, 32'sh0003_8000);
        add_item(OP_PUSH, 32'shFFFE_0000);
        add_item(OP_DIV, '1);
        add_item(OP_PUSH, -Q_ONE);
        add_item(OP_MUL, '0);
        add_item(OP_PUSH, Q_MIN);
        add_item(OP_PUSH, -Q_ONE);
        add_item(OP_DIV, '0);
        add_item(OP_UNUSED, '1);
        add_item(OP_CLEAR, '0);
        add_item(OP_QUERY, '0);

        while (pending_items.size() < ITEM_TOTAL) begin
            kind = $urandom_range(0, 99);
            if (kind < 63) begin
                if (kind < 8) begin
                    add_item(OP_CLEAR, pick_value());
                end
                n = $urandom_range(2, 5);
                for (int i = 0; i < n; i++) begin
                    add_item(OP_PUSH, pick_value());
                end
                for (int i = 0; i < n - 1; i++) begin
                    add_item(ARITH_OPS[$urandom_range(0, 3)], $signed($urandom()));
                end
            end else if (kind < 75) begin
                // Push burst: drives the stack to full and beyond.
                n = $urandom_range(8, 18);
                for (int i = 0; i < n; i++) begin
                    add_item(OP_PUSH, pick_value());
                end
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    add_item(3'($urandom_range(0, 7)), $signed($urandom()));
                end
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_results.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d operations and checked %0d results in %0d cycles.",
                 items_accepted, results_seen, cycle_count);
        $display("Statuses seen: %0d ok, %0d underflow, %0d divide by zero, %0d stack full.",
                 status_seen[ST_OK], status_seen[ST_UNDERFLOW],
                 status_seen[ST_DIVZERO], status_seen[ST_FULL]);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
